### hw/rtl/scfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC check package
// Shared types, constants and the CRC-8 byte step for the frame checker.
// ----------------------------------------------------------------------------
package scfc_pkg;

	localparam logic [7:0] CRC_INIT     = 8'hFF;
	localparam logic [7:0] CRC_TOP_BIT  = 8'h80;
	localparam logic [7:0] POLY_RESET   = 8'h31;

	// Byte positions inside the six-byte frame.
	localparam logic [2:0] POS_W0_HI  = 3'd0;
	localparam logic [2:0] POS_W0_LO  = 3'd1;
	localparam logic [2:0] POS_W0_CRC = 3'd2;
	localparam logic [2:0] POS_W1_HI  = 3'd3;
	localparam logic [2:0] POS_W1_LO  = 3'd4;
	localparam logic [2:0] POS_W1_CRC = 3'd5;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FIRST_BAD = 2'd1;
	localparam logic [1:0] STATUS_SECOND_BAD = 2'd2;

	typedef struct packed {
		logic [15:0] first_word;
		logic [15:0] second_word;
		logic [1:0]  frame_status;
	} result_t;

	// One byte of an MSB-first CRC-8 with implicit x^8 term.
	function automatic logic [7:0] crc_byte(input logic [7:0] crc,
	                                        input logic [7:0] data,
	                                        input logic [7:0] poly);
		logic [7:0] v;
		v = crc ^ data;
		for (int k = 0; k < 8; k++) begin
			if ((v & CRC_TOP_BIT) != 8'h00) begin
				v = {v[6:0], 1'b0} ^ poly;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

endpackage

### hw/rtl/scfc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame byte channel
// Valid/ready channel that carries one received frame byte per item.
// ----------------------------------------------------------------------------
interface scfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       frame_start;

	modport source (output valid, output rx_byte, output frame_start, input ready);
	modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

### hw/rtl/scfc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame result channel
// Valid/ready channel that carries the checked words and the frame status.
// ----------------------------------------------------------------------------
interface scfc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] first_word;
	logic [15:0] second_word;
	logic [1:0]  frame_status;

	modport source (output valid, output first_word, output second_word,
	                output frame_status, input ready);
	modport sink   (input valid, input first_word, input second_word,
	                input frame_status, output ready);
endinterface

### hw/rtl/scfc_frame_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame checker core
// Holds the frame state and the polynomial register and processes one byte
// in each cycle in which step is high.
// ----------------------------------------------------------------------------
module scfc_frame_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [7:0]            cfg_wr_data,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_start,
	output logic                  res_valid,
	output scfc_pkg::result_t     res
);

	logic [7:0]  crc_polynomial_q;
	logic [2:0]  byte_position_q, byte_position_d;
	logic [7:0]  crc_remainder_q, crc_remainder_d;
	logic [15:0] word_assembly_q, word_assembly_d;
	logic [15:0] pending_first_word_q, pending_first_word_d;
	logic        first_word_bad_q, first_word_bad_d;
	logic [15:0] good_first_word_q, good_first_word_d;
	logic [15:0] good_second_word_q, good_second_word_d;
	logic [2:0]  pos;
	logic [7:0]  crc_next;

	always_comb begin
		if (frame_start || (byte_position_q > scfc_pkg::POS_W1_CRC)) begin
			pos = scfc_pkg::POS_W0_HI;
		end else begin
			pos = byte_position_q;
		end
	end

	// Start bytes always seed from the init value; other bytes chain.
	assign crc_next = scfc_pkg::crc_byte(
		((pos == scfc_pkg::POS_W0_HI) || (pos == scfc_pkg::POS_W1_HI)) ?
			scfc_pkg::CRC_INIT : crc_remainder_q,
		rx_byte, crc_polynomial_q);

	always_comb begin
		byte_position_d      = 3'(pos + 3'd1);
		crc_remainder_d      = crc_remainder_q;
		word_assembly_d      = word_assembly_q;
		pending_first_word_d = pending_first_word_q;
		first_word_bad_d     = first_word_bad_q;
		good_first_word_d    = good_first_word_q;
		good_second_word_d   = good_second_word_q;
		res_valid            = 1'b0;
		res.frame_status     = scfc_pkg::STATUS_OK;
		case (pos) inside
			scfc_pkg::POS_W0_HI, scfc_pkg::POS_W1_HI: begin
				crc_remainder_d = crc_next;
				word_assembly_d = {rx_byte, 8'h00};
			end
			scfc_pkg::POS_W0_LO, scfc_pkg::POS_W1_LO: begin
				crc_remainder_d = crc_next;
				word_assembly_d = {word_assembly_q[15:8], rx_byte};
			end
			scfc_pkg::POS_W0_CRC: begin
				first_word_bad_d     = (crc_remainder_q != rx_byte);
				pending_first_word_d = word_assembly_q;
				crc_remainder_d      = scfc_pkg::CRC_INIT;
			end
			scfc_pkg::POS_W1_CRC: begin
				res_valid       = 1'b1;
				byte_position_d = scfc_pkg::POS_W0_HI;
				crc_remainder_d = scfc_pkg::CRC_INIT;
				if (first_word_bad_q) begin
					res.frame_status = scfc_pkg::STATUS_FIRST_BAD;
				end else if (crc_remainder_q != rx_byte) begin
					res.frame_status = scfc_pkg::STATUS_SECOND_BAD;
				end else begin
					good_first_word_d  = pending_first_word_q;
					good_second_word_d = word_assembly_q;
				end
			end
			default: begin
				byte_position_d = byte_position_q;
			end
		endcase
		res.first_word  = good_first_word_d;
		res.second_word = good_second_word_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_polynomial_q     <= scfc_pkg::POLY_RESET;
			byte_position_q      <= scfc_pkg::POS_W0_HI;
			crc_remainder_q      <= scfc_pkg::CRC_INIT;
			word_assembly_q      <= 16'h0000;
			pending_first_word_q <= 16'h0000;
			first_word_bad_q     <= 1'b0;
			good_first_word_q    <= 16'h0000;
			good_second_word_q   <= 16'h0000;
		end else begin
			if (cfg_wr_en) begin
				crc_polynomial_q <= cfg_wr_data;
			end
			if (step) begin
				byte_position_q      <= byte_position_d;
				crc_remainder_q      <= crc_remainder_d;
				word_assembly_q      <= word_assembly_d;
				pending_first_word_q <= pending_first_word_d;
				first_word_bad_q     <= first_word_bad_d;
				good_first_word_q    <= good_first_word_d;
				good_second_word_q   <= good_second_word_d;
			end
		end
	end

endmodule

### hw/rtl/sensor_frame_crc_check_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame CRC check unit
// Checks six-byte measurement frames (two words, each with a CRC-8 byte) and
// reports the latest good words with a status once per frame.
// ----------------------------------------------------------------------------
// Usage: frame bytes enter on the rx channel, one byte per item, with
// frame_start marking the first byte of a frame. A start mark drops any
// partial frame; without marks the bytes run on and wrap after six.
// On the sixth byte of a frame one item leaves on the res channel with the
// latest good first and second word and the frame status (ok, first word
// CRC bad, second word CRC bad). Stored words change only when both CRCs
// match, so a bad frame repeats the previous good pair.
// The polynomial is to be written through cfg_wr_en/cfg_wr_data while idle,
// which the block itself does not enforce. The sixth byte passes the input
// register and then the result register before res.valid rises; the single
// input register accepts one byte per cycle unless a waiting result stalls.
// Reset clears the frame position, sets the CRC to its init value, clears the
// stored words and loads polynomial 0x31. When the receiver stalls with a
// result waiting, the input register still takes one more byte, then holds
// it and drops rx.ready until the result is taken.
// ----------------------------------------------------------------------------
module sensor_frame_crc_check_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	scfc_in_if.sink    rx,
	scfc_out_if.source res
);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] rx_byte_s1;
	logic       frame_start_s1;

	// Result register.
	logic              res_valid_q;
	scfc_pkg::result_t res_q;

	logic              advance;
	logic              core_valid;
	scfc_pkg::result_t core_res;

	// The stage moves on when the result register is free or is being
	// emptied this cycle, so a new result never overwrites one that waits.
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			rx_byte_s1     <= rx.rx_byte;
			frame_start_s1 <= rx.frame_start;
		end
	end

	scfc_frame_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.step        (advance),
		.rx_byte     (rx_byte_s1),
		.frame_start (frame_start_s1),
		.res_valid   (core_valid),
		.res         (core_res)
	);

	// A new result takes priority over clearing the one just taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && core_valid) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			res_q <= core_res;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.first_word   = res_q.first_word;
	assign res.second_word  = res_q.second_word;
	assign res.frame_status = res_q.frame_status;

endmodule
